// ===== rtl/alts_pkg.sv =====
// Shared constants and character-class helpers for the assembly line token scanner.
package alts_pkg;

    localparam int unsigned CHAR_BITS    = 8;
    localparam int unsigned OUT_LEN_BITS = 16;
    localparam int unsigned BAD_LEN      = 5;
    localparam int unsigned BAD_POS_BITS = 3;
    localparam int unsigned HEX_RUN_BITS = 2;

    localparam logic [CHAR_BITS-1:0] CH_COLON   = 8'h3A;  // ':'
    localparam logic [CHAR_BITS-1:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [CHAR_BITS-1:0] CH_LT      = 8'h3C;  // '<'
    localparam logic [CHAR_BITS-1:0] CH_HASH    = 8'h23;  // '#'
    localparam logic [CHAR_BITS-1:0] CH_SEMI    = 8'h3B;  // ';'
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [BAD_POS_BITS-1:0] BAD_LAST = 3'd4;
    localparam logic [HEX_RUN_BITS-1:0] HEX_FULL = 2'd2;

    // Characters of the "(bad)" marker by match position.
    function automatic logic [CHAR_BITS-1:0] bad_char(input logic [BAD_POS_BITS-1:0] pos);
        logic [CHAR_BITS-1:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h28;  // '('
            3'd1:    ch = 8'h62;  // 'b'
            3'd2:    ch = 8'h61;  // 'a'
            3'd3:    ch = 8'h64;  // 'd'
            3'd4:    ch = 8'h29;  // ')'
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_hex(input logic [CHAR_BITS-1:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

// ===== rtl/assembly_line_token_scanner.sv =====
// Top level of the assembly line token scanner: one character per request in, verdicts out.
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+------------------------------
//  s_axis  | in  | [7:0] char_code                         | [0] at_eof, [1] scan_start
//  m_axis  | out | [0] found, [16:1] token_length, pad 0s  | [0] token_kind
//
//  Throughput: one character per cycle while m_axis is not stalled. A verdict passes from
//  its request through the input register, then scan logic into the output register.
//  The scan state updates when the input register hands its character on; that needs
//  the output register empty or being drained in the same cycle.
//  Reset (i_rst_n low, synchronous) empties both registers and returns to idle.
//  A stall on m_axis backs up into s_axis_tready after at most one more request.
module assembly_line_token_scanner #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]  s_axis_tuser,   // [0] at_eof, [1] scan_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] found, [16:1] token_length, [23:17] zero
    output logic [0:0]  m_axis_tuser    // [0] token_kind
);

    localparam int unsigned CB = alts_pkg::CHAR_BITS;
    localparam int unsigned OB = alts_pkg::OUT_LEN_BITS;
    localparam int unsigned PB = alts_pkg::BAD_POS_BITS;
    localparam int unsigned HB = alts_pkg::HEX_RUN_BITS;

    // ---- input register ----
    logic          r_in_valid;
    logic [CB-1:0] r_char;
    logic          r_eof;
    logic          r_start;

    // ---- scan state ----
    logic                   r_scanning,  n_scanning;
    logic                   r_dump,      n_dump;
    logic                   r_seen,      n_seen;
    logic                   r_bad_live,  n_bad_live;
    logic [PB-1:0]          r_bad_pos,   n_bad_pos;
    logic                   r_byte_poss, n_byte_poss;
    logic [HB-1:0]          r_hex_run,   n_hex_run;
    logic [LENGTH_BITS-1:0] r_count,     n_count;

    // ---- output register ----
    logic          r_out_valid;
    logic          r_found,  n_found;
    logic          r_kind,   n_kind;
    logic [OB-1:0] r_len;
    logic          n_emit;

    logic          advance;
    logic [OB-1:0] count_sat;

    // The scan step runs when the output slot can take a possible verdict.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_len, r_found};
    assign m_axis_tuser  = r_kind;

    // Clamp the running count to the 16-bit result field.
    generate
        if (LENGTH_BITS > OB) begin : g_clamp
            assign count_sat = (|r_count[LENGTH_BITS-1:OB]) ? {OB{1'b1}} : r_count[OB-1:0];
        end else if (LENGTH_BITS == OB) begin : g_same
            assign count_sat = r_count;
        end else begin : g_widen
            assign count_sat = {{(OB-LENGTH_BITS){1'b0}}, r_count};
        end
    endgenerate

    // Scan step for the character held in the input register.
    always_comb begin
        logic go;
        logic fin;
        logic ok;
        logic kind;
        logic cons;
        logic bad_done;

        n_scanning  = r_scanning;
        n_dump      = r_dump;
        n_seen      = r_seen;
        n_bad_live  = r_bad_live;
        n_bad_pos   = r_bad_pos;
        n_byte_poss = r_byte_poss;
        n_hex_run   = r_hex_run;
        n_count     = r_count;
        go          = 1'b1;
        fin         = 1'b0;
        ok          = 1'b0;
        kind        = 1'b0;
        cons        = 1'b0;
        bad_done    = 1'b0;

        // A start marker aborts any open scan and opens a fresh one.
        if (r_start) begin
            n_scanning  = 1'b1;
            n_dump      = 1'b0;
            n_seen      = 1'b0;
            n_bad_live  = 1'b1;
            n_bad_pos   = '0;
            n_byte_poss = 1'b1;
            n_hex_run   = '0;
            n_count     = '0;
            if (!r_eof && r_char == alts_pkg::CH_COLON) begin
                fin = 1'b1;
                go  = 1'b0;
            end
        end else if (!r_scanning) begin
            go = 1'b0;
        end

        if (go) begin
            if (n_dump) begin
                // Memory dump runs to newline or end of input.
                if (r_eof || r_char == alts_pkg::CH_NEWLINE) begin
                    fin  = 1'b1;
                    ok   = 1'b1;
                    kind = 1'b1;
                end else begin
                    cons = 1'b1;
                end
            end else if (!r_eof && r_char == alts_pkg::CH_DOT) begin
                n_dump = 1'b1;
                cons   = 1'b1;
            end else if (!r_eof && !n_seen && r_char == alts_pkg::CH_LT) begin
                fin = 1'b1;
            end else if (r_eof || r_char == alts_pkg::CH_NEWLINE ||
                         r_char == alts_pkg::CH_HASH || r_char == alts_pkg::CH_SEMI) begin
                fin = 1'b1;
                ok  = n_seen;
            end else if (!alts_pkg::is_space(r_char)) begin
                // "(bad)" matcher, whitespace skipped
                if (n_bad_live && r_char == alts_pkg::bad_char(n_bad_pos)) begin
                    if (n_bad_pos == alts_pkg::BAD_LAST) begin
                        bad_done = 1'b1;
                        fin      = 1'b1;
                    end else begin
                        n_bad_pos = n_bad_pos + 1'b1;
                    end
                end else begin
                    n_bad_live = 1'b0;
                end
                if (!bad_done) begin
                    // First word as a hex byte: two hex digits then whitespace.
                    if (n_hex_run >= alts_pkg::HEX_FULL) begin
                        n_byte_poss = 1'b0;
                    end else if (n_byte_poss) begin
                        if (alts_pkg::is_hex(r_char)) begin
                            n_hex_run = n_hex_run + 1'b1;
                        end else begin
                            n_hex_run   = '0;
                            n_byte_poss = 1'b0;
                        end
                    end
                    n_seen = 1'b1;
                    cons   = 1'b1;
                end
            end else if (n_byte_poss && n_hex_run >= alts_pkg::HEX_FULL) begin
                fin = 1'b1;
            end else begin
                cons = 1'b1;
            end
        end

        if (cons && !(&n_count)) begin
            n_count = n_count + 1'b1;
        end

        n_emit  = fin;
        n_found = ok;
        n_kind  = ok & kind;

        if (fin) begin
            n_scanning  = 1'b0;
            n_dump      = 1'b0;
            n_seen      = 1'b0;
            n_bad_live  = 1'b1;
            n_bad_pos   = '0;
            n_byte_poss = 1'b1;
            n_hex_run   = '0;
            n_count     = '0;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_char  <= s_axis_tdata;
            r_eof   <= s_axis_tuser[0];
            r_start <= s_axis_tuser[1];
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning  <= 1'b0;
            r_dump      <= 1'b0;
            r_seen      <= 1'b0;
            r_bad_live  <= 1'b1;
            r_bad_pos   <= '0;
            r_byte_poss <= 1'b1;
            r_hex_run   <= '0;
            r_count     <= '0;
        end else if (advance) begin
            r_scanning  <= n_scanning;
            r_dump      <= n_dump;
            r_seen      <= n_seen;
            r_bad_live  <= n_bad_live;
            r_bad_pos   <= n_bad_pos;
            r_byte_poss <= n_byte_poss;
            r_hex_run   <= n_hex_run;
            r_count     <= n_count;
        end
    end

    // Output register; the length is taken before the state clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_found <= n_found;
            r_kind  <= n_kind;
            r_len   <= n_found ? count_sat : '0;
        end
    end

endmodule
